>>> rtl/pict_pkg.sv
// Shared widths, register codes, reset values and control types of the Tustin PI controller.
package pict_pkg;

	localparam int ACC_WIDTH_DEF = 48;
	localparam int WORD_W        = 32;
	localparam int LIM_W         = 31;
	localparam int ERR_W         = 33;
	localparam int MUL_W         = 33;
	localparam int PROD_W        = 2 * MUL_W;
	localparam int COEF_W        = 64;
	localparam int HALF_W        = 32;
	localparam int FRAC_BITS     = 33;
	localparam int KP_ALIGN      = 17;
	localparam int Q_W           = 16;
	localparam int REM_W         = LIM_W + 1;
	localparam int CNT_W         = 4;
	localparam int CFG_IDX_W     = 3;

	localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_GAIN = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DRIVE_LIMIT   = 3'd3;

	localparam logic [WORD_W-1:0] PROP_GAIN_RST     = 32'd65536;
	localparam logic [WORD_W-1:0] INTEGRAL_GAIN_RST = 32'd0;
	localparam logic [LIM_W-1:0]  SAMPLE_PERIOD_RST = 31'd655;
	localparam logic [LIM_W-1:0]  DRIVE_LIMIT_RST   = 31'd65536;

	localparam logic [Q_W-1:0] FRAC_MAX = 16'h7fff;

	typedef struct packed {
		logic mul_en;
		logic acc_init;
		logic acc_add;
		logic add_hi;
	} mac_ctl_t;

endpackage

>>> rtl/pict_mac.sv
// Shared 33x33 signed multiplier with a registered product and a wide accumulator.
module pict_mac #(
	parameter int SUM_W = 100
) (
	input  logic                              clk,
	input  pict_pkg::mac_ctl_t                ctl,
	input  logic signed [pict_pkg::MUL_W-1:0] op_a,
	input  logic signed [pict_pkg::MUL_W-1:0] op_b,
	input  logic        [SUM_W-1:0]           acc_seed,
	output logic        [pict_pkg::PROD_W-1:0] prod,
	output logic        [SUM_W-1:0]           acc
);

	logic signed [pict_pkg::PROD_W-1:0] prod_q;
	logic        [SUM_W-1:0]            acc_q;
	logic        [SUM_W-1:0]            prod_ext;
	logic        [SUM_W-1:0]            term;

	assign prod_ext = {{(SUM_W - pict_pkg::PROD_W){prod_q[pict_pkg::PROD_W-1]}}, prod_q};
	// upper partial products carry a weight of 2^32
	assign term = ctl.add_hi ? {prod_ext[SUM_W-pict_pkg::HALF_W-1:0], {pict_pkg::HALF_W{1'b0}}}
		: prod_ext;

	always_ff @(posedge clk) begin
		if (ctl.mul_en) begin
			prod_q <= op_a * op_b;
		end
		if (ctl.acc_init) begin
			acc_q <= acc_seed;
		end else if (ctl.acc_add) begin
			acc_q <= acc_q + term;
		end
	end

	assign prod = prod_q;
	assign acc  = acc_q;

endmodule

>>> rtl/pict_div.sv
// Restoring divider: 16-bit quotient of mag * 2^15 / lim for mag no larger than lim.
module pict_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [pict_pkg::LIM_W-1:0]    mag,
	input  logic [pict_pkg::LIM_W-1:0]    lim,
	output logic                          done,
	output logic [pict_pkg::Q_W-1:0]      quo
);

	logic                           run_q;
	logic                           done_q;
	logic [pict_pkg::CNT_W-1:0]     cnt_q;
	logic [pict_pkg::REM_W-1:0]     rem_q;
	logic [pict_pkg::Q_W-1:0]       quo_q;
	logic [pict_pkg::REM_W-1:0]     trial;
	logic [pict_pkg::REM_W-1:0]     lim_ext;
	logic                           fits;

	assign lim_ext = {1'b0, lim};
	// first step compares mag itself, later steps the doubled remainder
	assign trial = (cnt_q == '0) ? rem_q : {rem_q[pict_pkg::REM_W-2:0], 1'b0};
	assign fits  = (trial >= lim_ext);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == pict_pkg::CNT_W'(pict_pkg::Q_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {1'b0, mag};
			quo_q <= '0;
		end else if (run_q) begin
			rem_q <= fits ? (trial - lim_ext) : trial;
			quo_q <= {quo_q[pict_pkg::Q_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

>>> rtl/pi_controller_tustin.sv
// Tustin PI controller top level: config registers, sequencer, state and output register.
//
// Input channel: in_valid / in_stall carry target_value and measured_value; an item
// transfers when in_valid is high and in_stall low. Output channel: out_valid / out_stall
// carry drive_fraction (Q1.15) and clamped, one result per input item.
// Configuration: cfg_valid / cfg_ready with cfg_index and cfg_data; cfg_ready is always
// high. Index 0 kp, 1 ki, 2 sample period, 3 drive limit; other indexes are ignored.
// Write registers only while no item is in flight.
// One 33x33 multiplier runs five products (ki*T, then four 32-bit halves of the two
// coefficients against the two errors) into a ~100-bit accumulator, then a one-bit-per-cycle
// divider does the normalization. One item is in work at a time: in_stall stays high from
// transfer until the result is loaded, so the next item cannot transfer before then.
// A finished result waits in the output register while out_stall is high; the next
// item can transfer meanwhile and holds before its output load until the slot frees.
// Reset clears the sequencer, the stored error and raw command, and the registers
// to their defaults (kp 1.0, ki 0, T 655/65536, limit 1.0); no result is pending.
module pi_controller_tustin #(
	parameter int ACC_WIDTH = pict_pkg::ACC_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [pict_pkg::WORD_W-1:0]  target_value,
	input  logic signed [pict_pkg::WORD_W-1:0]  measured_value,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [pict_pkg::Q_W-1:0]     drive_fraction,
	output logic                                clamped,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic        [pict_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic        [pict_pkg::WORD_W-1:0]  cfg_data
);

	localparam int SUM_W = ((ACC_WIDTH + pict_pkg::FRAC_BITS > 97) ?
		ACC_WIDTH + pict_pkg::FRAC_BITS : 97) + 3;
	localparam int SH_W  = SUM_W - pict_pkg::FRAC_BITS;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_KIT  = 4'd1;
	localparam logic [3:0] ST_COEF = 4'd2;
	localparam logic [3:0] ST_M0   = 4'd3;
	localparam logic [3:0] ST_M1   = 4'd4;
	localparam logic [3:0] ST_M2   = 4'd5;
	localparam logic [3:0] ST_M3   = 4'd6;
	localparam logic [3:0] ST_M4   = 4'd7;
	localparam logic [3:0] ST_SAT  = 4'd8;
	localparam logic [3:0] ST_LIM  = 4'd9;
	localparam logic [3:0] ST_DIV  = 4'd10;
	localparam logic [3:0] ST_OUT  = 4'd11;

	logic [3:0] state_q, state_d;

	logic [pict_pkg::WORD_W-1:0] kp_q, ki_q;
	logic [pict_pkg::LIM_W-1:0]  per_q, lim_q;

	logic [pict_pkg::ERR_W-1:0]  err_q, eprev_q;
	logic [ACC_WIDTH-1:0]        rawprev_q;
	logic [pict_pkg::COEF_W-1:0] c1_q, c0_q;
	logic                        flag_q, neg_q;
	logic                        out_valid_q;
	logic [pict_pkg::Q_W-1:0]    frac_q;
	logic                        clamped_q;

	pict_pkg::mac_ctl_t                  ctl;
	logic signed [pict_pkg::MUL_W-1:0]   op_a, op_b;
	logic [SUM_W-1:0]                    acc_seed, acc;
	logic [pict_pkg::PROD_W-1:0]         prod;

	logic                           in_xfer, out_load;
	logic [pict_pkg::COEF_W-1:0]    kit, kp_al;
	logic [SH_W-1:0]                sh;
	logic [SH_W-ACC_WIDTH:0]        sh_top;
	logic                           sh_fits;
	logic [ACC_WIDTH-1:0]           acc_max, acc_min, raw_sat;
	logic [pict_pkg::LIM_W-1:0]     lim_eff, mag;
	logic [ACC_WIDTH-1:0]           lim_ext, abs_raw;
	logic                           over_hi, over_lo;
	logic                           div_start, div_done;
	logic [pict_pkg::Q_W-1:0]       quo, frac;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_xfer   = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q  <= pict_pkg::PROP_GAIN_RST;
			ki_q  <= pict_pkg::INTEGRAL_GAIN_RST;
			per_q <= pict_pkg::SAMPLE_PERIOD_RST;
			lim_q <= pict_pkg::DRIVE_LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				pict_pkg::REG_PROP_GAIN:     kp_q  <= cfg_data;
				pict_pkg::REG_INTEGRAL_GAIN: ki_q  <= cfg_data;
				pict_pkg::REG_SAMPLE_PERIOD: per_q <= cfg_data[pict_pkg::LIM_W-1:0];
				pict_pkg::REG_DRIVE_LIMIT:   lim_q <= cfg_data[pict_pkg::LIM_W-1:0];
				default: ;
			endcase
		end
	end

	// coefficient terms: ki*T has 32 fraction bits, kp is aligned up to 33
	assign kit   = prod[pict_pkg::COEF_W-1:0];
	assign kp_al = {{(pict_pkg::COEF_W - pict_pkg::WORD_W){kp_q[pict_pkg::WORD_W-1]}}, kp_q}
		<< pict_pkg::KP_ALIGN;

	// raw_prev * 2^33 plus the rounding half
	assign acc_seed = {{(SUM_W - ACC_WIDTH - pict_pkg::FRAC_BITS){rawprev_q[ACC_WIDTH-1]}},
		rawprev_q, 1'b1, {(pict_pkg::FRAC_BITS - 1){1'b0}}};

	// saturate the rounded sum to the accumulator width
	assign sh      = acc[SUM_W-1:pict_pkg::FRAC_BITS];
	assign sh_top  = sh[SH_W-1:ACC_WIDTH-1];
	assign sh_fits = (&sh_top) || !(|sh_top);
	assign acc_max = {1'b0, {(ACC_WIDTH-1){1'b1}}};
	assign acc_min = {1'b1, {(ACC_WIDTH-1){1'b0}}};
	assign raw_sat = sh_fits ? sh[ACC_WIDTH-1:0] : (sh[SH_W-1] ? acc_min : acc_max);

	// clamp against the limit; a zero limit acts as one unit
	assign lim_eff = (lim_q == '0) ? pict_pkg::LIM_W'(1) : lim_q;
	assign lim_ext = {{(ACC_WIDTH - pict_pkg::LIM_W){1'b0}}, lim_eff};
	assign over_hi = $signed(rawprev_q) > $signed(lim_ext);
	assign over_lo = $signed(rawprev_q) < -$signed(lim_ext);
	assign abs_raw = rawprev_q[ACC_WIDTH-1] ? -rawprev_q : rawprev_q;
	assign mag     = (over_hi || over_lo) ? lim_eff : abs_raw[pict_pkg::LIM_W-1:0];

	assign div_start = (state_q == ST_LIM);

	// +1.0 saturates to the largest positive code
	assign frac = neg_q ? -quo : (quo[pict_pkg::Q_W-1] ? pict_pkg::FRAC_MAX : quo);

	assign out_load = (state_q == ST_OUT) && (!out_valid_q || !out_stall);

	always_comb begin
		state_d      = state_q;
		ctl          = '0;
		op_a         = '0;
		op_b         = '0;
		ctl.acc_init = in_xfer;
		case (state_q)
			ST_IDLE: if (in_xfer) state_d = ST_KIT;
			ST_KIT: begin
				ctl.mul_en = 1'b1;
				op_a       = {ki_q[pict_pkg::WORD_W-1], ki_q};
				op_b       = {2'b00, per_q};
				state_d    = ST_COEF;
			end
			ST_COEF: state_d = ST_M0;
			ST_M0: begin
				ctl.mul_en = 1'b1;
				op_a       = {1'b0, c1_q[pict_pkg::HALF_W-1:0]};
				op_b       = err_q;
				state_d    = ST_M1;
			end
			ST_M1: begin
				ctl.mul_en  = 1'b1;
				ctl.acc_add = 1'b1;
				op_a        = {c1_q[pict_pkg::COEF_W-1],
					c1_q[pict_pkg::COEF_W-1:pict_pkg::HALF_W]};
				op_b        = err_q;
				state_d     = ST_M2;
			end
			ST_M2: begin
				ctl.mul_en  = 1'b1;
				ctl.acc_add = 1'b1;
				ctl.add_hi  = 1'b1;
				op_a        = {1'b0, c0_q[pict_pkg::HALF_W-1:0]};
				op_b        = eprev_q;
				state_d     = ST_M3;
			end
			ST_M3: begin
				ctl.mul_en  = 1'b1;
				ctl.acc_add = 1'b1;
				op_a        = {c0_q[pict_pkg::COEF_W-1],
					c0_q[pict_pkg::COEF_W-1:pict_pkg::HALF_W]};
				op_b        = eprev_q;
				state_d     = ST_M4;
			end
			ST_M4: begin
				ctl.acc_add = 1'b1;
				ctl.add_hi  = 1'b1;
				state_d     = ST_SAT;
			end
			ST_SAT: state_d = ST_LIM;
			ST_LIM: state_d = ST_DIV;
			ST_DIV: if (div_done) state_d = ST_OUT;
			ST_OUT: if (out_load) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			eprev_q     <= '0;
			rawprev_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_SAT) begin
				rawprev_q <= raw_sat;
				eprev_q   <= err_q;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			err_q <= {target_value[pict_pkg::WORD_W-1], target_value}
				- {measured_value[pict_pkg::WORD_W-1], measured_value};
		end
		if (state_q == ST_COEF) begin
			c1_q <= kit + kp_al;
			c0_q <= kit - kp_al;
		end
		if (state_q == ST_SAT) begin
			flag_q <= !sh_fits || ($signed(sh) > $signed(acc_max))
				|| ($signed(sh) < $signed(acc_min));
		end
		if (state_q == ST_LIM) begin
			flag_q <= flag_q || over_hi || over_lo;
			neg_q  <= rawprev_q[ACC_WIDTH-1];
		end
		if (out_load) begin
			frac_q    <= frac;
			clamped_q <= flag_q;
		end
	end

	pict_mac #(
		.SUM_W(SUM_W)
	) u_mac (
		.clk     (clk),
		.ctl     (ctl),
		.op_a    (op_a),
		.op_b    (op_b),
		.acc_seed(acc_seed),
		.prod    (prod),
		.acc     (acc)
	);

	pict_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.mag   (mag),
		.lim   (lim_eff),
		.done  (div_done),
		.quo   (quo)
	);

	assign out_valid      = out_valid_q;
	assign drive_fraction = frac_q;
	assign clamped        = clamped_q;

endmodule

>>> rtl/pict_chk.sv
// Port-level checks on the Tustin PI controller, bound to its top level.
module pict_chk (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_stall,
	input logic                            out_valid,
	input logic                            out_stall,
	input logic [pict_pkg::Q_W-1:0]        drive_fraction,
	input logic                            clamped
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(drive_fraction) && $stable(clamped))
		else $error("stalled result changed");

	// one item at a time: after a transfer the input side stalls
	a_busy_after_xfer: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input not stalled after transfer");

	// a new result is only loaded while an item is in work
	a_load_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared with no item in work");

	// no result can come out right after a transfer
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> !$rose(out_valid))
		else $error("result followed transfer too soon");

endmodule

bind pi_controller_tustin pict_chk u_pict_chk (.*);
